/* sv/tls_response_classifier_defines.svh */
// assertion macros for the tls response classifier checker
// no dependencies
`ifndef TLS_RESPONSE_CLASSIFIER_DEFINES_SVH
`define TLS_RESPONSE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("trc check failed");

// next-cycle implication, disabled while reset is low
`define TRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("trc check failed");

`endif

/* sv/trc_pkg.sv */
// shared types, codes and constants of the tls response classifier
// no dependencies
package trc_pkg;

	typedef enum logic [2:0] {
		CLS_NOT_TLS = 3'd0,
		CLS_MAYBE   = 3'd1,
		CLS_SSL30   = 3'd2,
		CLS_TLS10   = 3'd3,
		CLS_TLS11   = 3'd4,
		CLS_TLS12   = 3'd5,
		CLS_TLS13   = 3'd6
	} class_t;

	typedef enum logic [1:0] {
		RSN_NOT_MATCHED = 2'd0,
		RSN_HTTPS       = 2'd1,
		RSN_MATCHED     = 2'd2,
		RSN_NO_RESPONSE = 2'd3
	} reason_t;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_HANDSHAKE = 2'd1,
		KIND_ALERT     = 2'd2
	} kind_t;

	localparam logic [3:0] POS_SAT = 4'd11;
	localparam logic [3:0] POS_B0  = 4'd0;
	localparam logic [3:0] POS_B1  = 4'd1;
	localparam logic [3:0] POS_B2  = 4'd2;
	localparam logic [3:0] POS_B5  = 4'd5;
	localparam logic [3:0] POS_B6  = 4'd6;
	localparam logic [3:0] POS_B9  = 4'd9;
	localparam logic [3:0] POS_B10 = 4'd10;

	localparam logic [3:0] POS_MIN_LEN3   = 4'd2;
	localparam logic [3:0] POS_MIN_LEN7   = 4'd6;
	localparam logic [3:0] POS_MIN_LEN11  = 4'd10;
	localparam logic [3:0] POS_HTTPS_FULL = 4'd4;
	localparam logic [3:0] POS_EXT_FULL   = 4'd5;

	localparam logic [7:0] REC_HANDSHAKE = 8'h16;
	localparam logic [7:0] REC_ALERT     = 8'h15;
	localparam logic [7:0] VER_MAJOR     = 8'h03;
	localparam logic [7:0] VER_MAX       = 8'h04;
	localparam logic [7:0] DESC_PROTVER  = 8'd70;

	localparam logic [31:0] HTTPS_PREFIX = 32'h4854_5450;
	localparam logic [7:0]  HTTPS_LAST   = 8'h53;
	localparam logic [39:0] EXT_PREFIX   = 40'h00_2b00_0203;
	localparam logic [7:0]  EXT_LAST     = 8'h04;

	// reply state as seen by the classifier, current byte already merged
	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] h0;
		logic [7:0] h1;
		logic [7:0] h2;
		logic [7:0] h5;
		logic [7:0] h6;
		logic [7:0] h9;
		logic [7:0] h10;
		logic       https_seen;
		logic       ext_seen;
	} view_t;

	// packed so that class_code sits in the low bits
	typedef struct packed {
		logic [7:0] alert_desc;
		logic [7:0] alert_level;
		kind_t      record_kind;
		reason_t    reason_code;
		logic       success;
		class_t     class_code;
	} result_t;

	function automatic class_t version_class(input logic [7:0] v, input logic is13);
		class_t c;
		unique case (v)
			8'h00:   c = CLS_SSL30;
			8'h01:   c = CLS_TLS10;
			8'h02:   c = CLS_TLS11;
			8'h03:   c = is13 ? CLS_TLS13 : CLS_TLS12;
			default: c = CLS_NOT_TLS;
		endcase
		return c;
	endfunction

endpackage

/* sv/trc_state.sv */
// per-reply state: position count, kept header bytes and pattern windows
// depends on trc_pkg
module trc_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            req_type,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	output trc_pkg::view_t  view
);

	logic [3:0]  pos_q;
	logic [7:0]  h0_q, h1_q, h2_q, h5_q, h6_q, h9_q, h10_q;
	logic [31:0] https_win_q;
	logic [39:0] ext_win_q;
	logic        https_seen_q;
	logic        ext_seen_q;
	logic        https_hit;
	logic        ext_hit;
	logic        clear;

	assign https_hit = (pos_q >= trc_pkg::POS_HTTPS_FULL) &&
		(https_win_q == trc_pkg::HTTPS_PREFIX) && (data_byte == trc_pkg::HTTPS_LAST);
	assign ext_hit = (pos_q >= trc_pkg::POS_EXT_FULL) &&
		(ext_win_q == trc_pkg::EXT_PREFIX) && (data_byte == trc_pkg::EXT_LAST);
	assign clear = req_type || last_byte;

	always_comb begin
		view.idx        = pos_q;
		view.h0         = (pos_q == trc_pkg::POS_B0)  ? data_byte : h0_q;
		view.h1         = (pos_q == trc_pkg::POS_B1)  ? data_byte : h1_q;
		view.h2         = (pos_q == trc_pkg::POS_B2)  ? data_byte : h2_q;
		view.h5         = (pos_q == trc_pkg::POS_B5)  ? data_byte : h5_q;
		view.h6         = (pos_q == trc_pkg::POS_B6)  ? data_byte : h6_q;
		view.h9         = (pos_q == trc_pkg::POS_B9)  ? data_byte : h9_q;
		view.h10        = (pos_q == trc_pkg::POS_B10) ? data_byte : h10_q;
		view.https_seen = https_seen_q || https_hit;
		view.ext_seen   = ext_seen_q || ext_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			h0_q         <= '0;
			h1_q         <= '0;
			h2_q         <= '0;
			h5_q         <= '0;
			h6_q         <= '0;
			h9_q         <= '0;
			h10_q        <= '0;
			https_win_q  <= '0;
			ext_win_q    <= '0;
			https_seen_q <= 1'b0;
			ext_seen_q   <= 1'b0;
		end else if (step) begin
			if (clear) begin
				pos_q        <= '0;
				h0_q         <= '0;
				h1_q         <= '0;
				h2_q         <= '0;
				h5_q         <= '0;
				h6_q         <= '0;
				h9_q         <= '0;
				h10_q        <= '0;
				https_win_q  <= '0;
				ext_win_q    <= '0;
				https_seen_q <= 1'b0;
				ext_seen_q   <= 1'b0;
			end else begin
				if (pos_q < trc_pkg::POS_SAT) begin
					pos_q <= pos_q + 4'd1;
				end
				h0_q         <= view.h0;
				h1_q         <= view.h1;
				h2_q         <= view.h2;
				h5_q         <= view.h5;
				h6_q         <= view.h6;
				h9_q         <= view.h9;
				h10_q        <= view.h10;
				https_win_q  <= {https_win_q[23:0], data_byte};
				ext_win_q    <= {ext_win_q[31:0], data_byte};
				https_seen_q <= view.https_seen;
				ext_seen_q   <= view.ext_seen;
			end
		end
	end

endmodule

/* sv/trc_decide.sv */
// ranks the reply and forms the result item
// depends on trc_pkg
module trc_decide (
	input  trc_pkg::view_t   view,
	input  logic             req_type,
	input  logic             tls13_probe,
	output trc_pkg::result_t result
);

	trc_pkg::class_t hs_cls;
	trc_pkg::class_t al_cls;
	logic            is_hs;
	logic            is_alert;

	assign hs_cls = trc_pkg::version_class(view.h10, tls13_probe && view.ext_seen);
	assign al_cls = trc_pkg::version_class(view.h2,
		!tls13_probe && (view.h6 == trc_pkg::DESC_PROTVER));
	assign is_hs = (view.h0 == trc_pkg::REC_HANDSHAKE) && (view.h1 == trc_pkg::VER_MAJOR) &&
		(view.h2 <= trc_pkg::VER_MAX) && (view.idx >= trc_pkg::POS_MIN_LEN11) &&
		(view.h9 == trc_pkg::VER_MAJOR);
	assign is_alert = (view.h0 == trc_pkg::REC_ALERT) && (view.h1 == trc_pkg::VER_MAJOR) &&
		(view.idx >= trc_pkg::POS_MIN_LEN7);

	always_comb begin
		result.class_code  = trc_pkg::CLS_NOT_TLS;
		result.success     = 1'b0;
		result.reason_code = trc_pkg::RSN_NOT_MATCHED;
		result.record_kind = trc_pkg::KIND_NONE;
		result.alert_level = '0;
		result.alert_desc  = '0;
		if (req_type) begin
			result.reason_code = trc_pkg::RSN_NO_RESPONSE;
		end else if (view.idx < trc_pkg::POS_MIN_LEN3) begin
			result.reason_code = trc_pkg::RSN_NOT_MATCHED;
		end else if (view.https_seen) begin
			result.class_code  = trc_pkg::CLS_MAYBE;
			result.success     = 1'b1;
			result.reason_code = trc_pkg::RSN_HTTPS;
		end else if (is_hs) begin
			if (hs_cls != trc_pkg::CLS_NOT_TLS) begin
				result.class_code  = hs_cls;
				result.success     = 1'b1;
				result.reason_code = trc_pkg::RSN_MATCHED;
				result.record_kind = trc_pkg::KIND_HANDSHAKE;
			end
		end else if (is_alert) begin
			if (al_cls != trc_pkg::CLS_NOT_TLS) begin
				result.class_code  = al_cls;
				result.success     = 1'b1;
				result.reason_code = trc_pkg::RSN_MATCHED;
				result.record_kind = trc_pkg::KIND_ALERT;
				result.alert_level = view.h5;
				result.alert_desc  = view.h6;
			end
		end
	end

endmodule

/* sv/tls_response_classifier.sv */
// The byte that ends a reply, or a timeout, passes through the input register and then
// loads the result register, from which the master side takes the result.
// Throughput: one byte per cycle; a byte that ends a reply waits in the input
// register only while the result register is full and not taken.
// Reset: arst_n clears the reply state, tls13_probe and both valid flags at once.
// depends on trc_pkg, trc_state, trc_decide
module tls_response_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,      // tls13_probe
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // req_type
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // class_code, success, reason_code, record_kind,
	                                    // alert_level, alert_desc
);

	logic             probe_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             req_s1;
	logic             last_s1;
	logic             out_valid_q;
	trc_pkg::result_t result_q;
	trc_pkg::result_t result;
	trc_pkg::view_t   view;
	logic             emits;
	logic             advance;
	logic             step;

	assign emits   = req_s1 || last_s1;
	assign advance = !valid_s1 || !emits || !out_valid_q || m_axis_tready;
	assign step    = valid_s1 && advance;

	assign s_axis_tready = advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	trc_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.req_type  (req_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.view      (view)
	);

	trc_decide u_decide (
		.view        (view),
		.req_type    (req_s1),
		.tls13_probe (probe_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= 1'b0;
		end else if (cfg_we) begin
			probe_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			req_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emits) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emits) begin
			result_q <= result;
		end
	end

endmodule

/* sv/trc_checker.sv */
// port-level checks of the tls response classifier, bound to the top level
// depends on trc_pkg and tls_response_classifier_defines.svh
`include "tls_response_classifier_defines.svh"

module trc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	logic [2:0] cls;
	logic       ok;
	logic [1:0] rsn;
	logic [1:0] kind;

	assign cls  = m_axis_tdata[2:0];
	assign ok   = m_axis_tdata[3];
	assign rsn  = m_axis_tdata[5:4];
	assign kind = m_axis_tdata[7:6];

	// stalled result holds
	`TRC_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// success exactly when some class was recognized
	`TRC_ASSERT_IMP(a_success_class, clk, arst_n, m_axis_tvalid,
		ok == (cls != trc_pkg::CLS_NOT_TLS))

	// success only with an https or protocol match
	`TRC_ASSERT_IMP(a_success_reason, clk, arst_n, m_axis_tvalid && ok,
		rsn == trc_pkg::RSN_HTTPS || rsn == trc_pkg::RSN_MATCHED)

	// alert bytes only travel with an alert record
	`TRC_ASSERT_IMP(a_alert_fields, clk, arst_n, m_axis_tvalid && kind != trc_pkg::KIND_ALERT,
		m_axis_tdata[23:8] == 16'd0)

	// timeout result carries no record
	`TRC_ASSERT_IMP(a_timeout, clk, arst_n, m_axis_tvalid && rsn == trc_pkg::RSN_NO_RESPONSE,
		kind == trc_pkg::KIND_NONE)

endmodule

bind tls_response_classifier trc_checker u_trc_checker (.*);
